// File: design/cswm_pkg.sv
`default_nettype none
package cswm_pkg;

  // default values of the top level parameters
  localparam int SAMPLE_BITS_DEF       = 24;
  localparam int MAX_WINDOW_LENGTH_DEF = 65536;
  localparam int COS_TABLE_BITS_DEF    = 10;

  // configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LENGTH      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP         = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COEF_CONSTANT      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COEF_FIRST_COSINE  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COEF_SECOND_COSINE = 3'd4;

  // register widths and reset values
  localparam int WL_BITS    = 17;
  localparam int PHASE_BITS = 32;
  localparam int COEF_BITS  = 16;

  localparam logic [WL_BITS-1:0]    WINDOW_LENGTH_RST      = 17'd1024;
  localparam logic [PHASE_BITS-1:0] PHASE_STEP_RST         = 32'd4198405;
  localparam logic [COEF_BITS-1:0]  COEF_CONSTANT_RST      = 16'd27525;
  localparam logic [COEF_BITS-1:0]  COEF_FIRST_COSINE_RST  = 16'd32768;
  localparam logic [COEF_BITS-1:0]  COEF_SECOND_COSINE_RST = 16'd5243;

  // fixed point layout
  localparam int ROM_BITS    = 16;  // table entry, 0..32768 in q1.15
  localparam int COS_BITS    = 17;  // signed cosine
  localparam int COS_SHIFT   = 15;  // a0 scaled by one in q1.15
  localparam int ACC_BITS    = 34;  // weight in q.31, three terms
  localparam int W_SHIFT     = 7;   // q.31 down to q.24
  localparam int W_BITS      = ACC_BITS - W_SHIFT;
  localparam int W_ROUND     = 64;
  localparam int Y_SHIFT     = 24;
  localparam int Y_ROUND     = 8388608;

  // cordic used to build the quarter-wave table
  localparam int CORDIC_STEPS = 24;
  localparam longint CORDIC_GAIN_START = 64'sd652032874;
  localparam longint TURN_ATAN [CORDIC_STEPS] = '{
    64'sd536870912, 64'sd316933406, 64'sd167458908, 64'sd85004758,
    64'sd42667332,  64'sd21354465,  64'sd10679839,  64'sd5340245,
    64'sd2670163,   64'sd1335087,   64'sd667544,    64'sd333772,
    64'sd166886,    64'sd83443,     64'sd41721,     64'sd20861,
    64'sd10430,     64'sd5215,      64'sd2608,      64'sd1304,
    64'sd652,       64'sd326,       64'sd163,       64'sd81
  };

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK1,
    ST_LOOK2,
    ST_WEIGHT,
    ST_SCALE,
    ST_DONE
  } state_t;

  // cosine of a q2.30 angle (one quarter turn = 2^30), rounded to q1.15
  function automatic logic [ROM_BITS-1:0] cordic_cos(input longint angle);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint r;
    x = CORDIC_GAIN_START;
    y = 0;
    z = angle;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - TURN_ATAN[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + TURN_ATAN[i];
      end
    end
    r = (x + 64'sd16384) >>> 15;
    if (r < 0) r = 0;
    if (r > 32768) r = 32768;
    return r[ROM_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// File: design/cswm_cos_rom.sv
`default_nettype none
module cswm_cos_rom import cswm_pkg::*; #(
  parameter int COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic [COS_TABLE_BITS:0]   addr,
  output logic      [ROM_BITS-1:0]       data
);

  localparam int ROM_DEPTH = (1 << COS_TABLE_BITS) + 1;

  typedef logic [ROM_BITS-1:0] rom_t [ROM_DEPTH];

  // quarter wave, entry j is cos(pi/2 * j / 2^COS_TABLE_BITS)
  function automatic rom_t build_rom();
    rom_t t;
    for (int j = 0; j < ROM_DEPTH; j++) begin
      t[j] = cordic_cos(longint'(j) << (30 - COS_TABLE_BITS));
    end
    return t;
  endfunction

  localparam rom_t COS_ROM = build_rom();

  always_ff @(posedge clk) begin
    data <= COS_ROM[addr];
  end

endmodule
`default_nettype wire

// File: design/cosine_sum_window_multiplier.sv
`default_nettype none
// cosine-sum window multiplier: sample_out = sample_in * (a0 - a1*cos(t) + a2*cos(2t))
// with t = 2*pi*k*phase_step/2^32, k the sample's place in the window (blackman, hann, hamming)
//
// channels
//   s_*   one sample per request, s_tuser = restart (sample becomes index zero)
//   m_*   one windowed sample per request, m_tlast = last sample of the window
//   cfg_* register writes (window length, phase step, a0, a1, a2), always ready;
//         write only while no sample is in flight
//
// timing
//   one sample at a time: s_tready is high only in the idle state, so a new sample is
//   taken once the last has left the done step; m_tvalid rises after the look1, look2,
//   weight, scale and done steps. the work runs through one shared multiplier: a1*cos,
//   a2*cos(2t), sample*w, with two reads of the quarter-wave cosine rom in front of it
//
// reset: index and phase go to zero, registers take their default values
// (blackman, window of 1024)
// stall: the result waits in the output register; a following sample is taken
// and worked on, and it waits in the last step until the output register frees
module cosine_sum_window_multiplier import cswm_pkg::*; #(
  parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF,
  parameter int MAX_WINDOW_LENGTH = MAX_WINDOW_LENGTH_DEF,
  parameter int COS_TABLE_BITS    = COS_TABLE_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // input samples
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,   // sample_in
  input  wire logic                                  s_tuser,   // restart
  // windowed samples
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  output logic      [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,   // sample_out
  output logic                                       m_tlast,   // window_end
  // register writes
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0]             cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]              cfg_data
);

  localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int MA_BITS   = (SAMPLE_BITS > COS_BITS) ? SAMPLE_BITS : COS_BITS;
  localparam int P_BITS    = MA_BITS + W_BITS;
  localparam int YW_BITS   = P_BITS - Y_SHIFT;
  localparam int IDX_BITS  = $clog2(MAX_WINDOW_LENGTH);
  localparam int CMP_BITS  = (IDX_BITS + 1 > WL_BITS) ? IDX_BITS + 1 : WL_BITS;
  localparam int ADDR_BITS = COS_TABLE_BITS + 1;

  // configuration registers
  logic [WL_BITS-1:0]    window_length;
  logic [PHASE_BITS-1:0] phase_step;
  logic [COEF_BITS-1:0]  coef_constant;
  logic [COEF_BITS-1:0]  coef_first_cosine;
  logic [COEF_BITS-1:0]  coef_second_cosine;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length      <= WINDOW_LENGTH_RST;
      phase_step         <= PHASE_STEP_RST;
      coef_constant      <= COEF_CONSTANT_RST;
      coef_first_cosine  <= COEF_FIRST_COSINE_RST;
      coef_second_cosine <= COEF_SECOND_COSINE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WINDOW_LENGTH:      window_length      <= cfg_data[WL_BITS-1:0];
        CFG_PHASE_STEP:         phase_step         <= cfg_data[PHASE_BITS-1:0];
        CFG_COEF_CONSTANT:      coef_constant      <= cfg_data[COEF_BITS-1:0];
        CFG_COEF_FIRST_COSINE:  coef_first_cosine  <= cfg_data[COEF_BITS-1:0];
        CFG_COEF_SECOND_COSINE: coef_second_cosine <= cfg_data[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  state_t state;
  state_t state_next;
  logic   s_accept;
  logic   out_load;

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_LOOK1;
      ST_LOOK1:  state_next = ST_LOOK2;
      ST_LOOK2:  state_next = ST_WEIGHT;
      ST_WEIGHT: state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_DONE;
      ST_DONE: begin
        // the output register must be free before the result moves in
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // window position
  logic [IDX_BITS-1:0]   sample_index;
  logic [PHASE_BITS-1:0] phase_acc;
  logic [CMP_BITS-1:0]   n_raw;
  logic [CMP_BITS-1:0]   n_eff;
  logic                  short_win;
  logic                  zero_start;
  logic [IDX_BITS-1:0]   idx_eff;
  logic [PHASE_BITS-1:0] phase_eff;
  logic                  is_last;

  always_comb begin
    n_raw      = CMP_BITS'(window_length);
    n_eff      = (n_raw > CMP_BITS'(MAX_WINDOW_LENGTH)) ? CMP_BITS'(MAX_WINDOW_LENGTH) : n_raw;
    short_win  = n_eff < CMP_BITS'(2);
    zero_start = s_tuser || short_win;
    idx_eff    = zero_start ? '0 : sample_index;
    phase_eff  = zero_start ? '0 : phase_acc;
    // a length cut mid-window ends the window at once
    is_last    = short_win || (CMP_BITS'(idx_eff) >= n_eff - CMP_BITS'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      phase_acc    <= '0;
    end else if (s_accept) begin
      sample_index <= is_last ? '0 : idx_eff + IDX_BITS'(1);
      phase_acc    <= is_last ? '0 : phase_eff + phase_step;
    end
  end

  // per-sample registers
  logic                          last_q;
  logic [PHASE_BITS-1:0]         phase_cur;
  logic signed [SAMPLE_BITS-1:0] sample_q;

  always_ff @(posedge clk) begin
    if (s_accept) begin
      last_q    <= is_last;
      phase_cur <= phase_eff;
      sample_q  <= $signed(s_tdata[SAMPLE_BITS-1:0]);
    end
  end

  // cosine rom: first read for the phase, second for twice the phase
  logic [PHASE_BITS-1:0]     rom_phase;
  logic [COS_TABLE_BITS-1:0] rom_step;
  logic [ADDR_BITS-1:0]      rom_addr;
  logic [ROM_BITS-1:0]       rom_data;
  logic                      cos_neg;
  logic signed [COS_BITS-1:0] cos_val;

  always_comb begin
    rom_phase = (state == ST_IDLE) ? phase_eff : {phase_cur[PHASE_BITS-2:0], 1'b0};
    rom_step  = rom_phase[PHASE_BITS-3 -: COS_TABLE_BITS];
    // odd quadrants read the table mirrored
    rom_addr  = rom_phase[PHASE_BITS-2]
              ? ADDR_BITS'(1 << COS_TABLE_BITS) - ADDR_BITS'(rom_step)
              : ADDR_BITS'(rom_step);
  end

  cswm_cos_rom #(
    .COS_TABLE_BITS(COS_TABLE_BITS)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  always_comb begin
    // second and third quadrants are negative
    cos_neg = (state == ST_LOOK1) ? (phase_cur[PHASE_BITS-1] ^ phase_cur[PHASE_BITS-2])
                                  : (phase_cur[PHASE_BITS-2] ^ phase_cur[PHASE_BITS-3]);
    cos_val = cos_neg ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
  end

  // shared multiplier
  logic signed [MA_BITS-1:0]  mul_a;
  logic signed [W_BITS-1:0]   mul_b;
  logic signed [P_BITS-1:0]   mul_p;
  logic signed [P_BITS-1:0]   prod;
  logic signed [ACC_BITS-1:0] acc;
  logic signed [ACC_BITS-1:0] prod_acc;
  logic signed [ACC_BITS-1:0] w_sum;
  logic signed [W_BITS-1:0]   weight;

  always_comb begin
    case (state)
      ST_LOOK1: begin
        mul_a = MA_BITS'(cos_val);
        mul_b = $signed(W_BITS'(coef_first_cosine));
      end
      ST_LOOK2: begin
        mul_a = MA_BITS'(cos_val);
        mul_b = $signed(W_BITS'(coef_second_cosine));
      end
      ST_SCALE: begin
        mul_a = MA_BITS'(sample_q);
        mul_b = weight;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p    = P_BITS'(mul_a) * P_BITS'(mul_b);
    prod_acc = $signed(prod[ACC_BITS-1:0]);
    w_sum    = acc + prod_acc + $signed(ACC_BITS'(W_ROUND));
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_LOOK1: begin
        prod <= mul_p;
        acc  <= $signed(ACC_BITS'({coef_constant, {COS_SHIFT{1'b0}}}));
      end
      ST_LOOK2: begin
        prod <= mul_p;
        acc  <= acc - prod_acc;
      end
      ST_WEIGHT: weight <= w_sum[ACC_BITS-1:W_SHIFT];
      ST_SCALE:  prod   <= mul_p;
      default: ;
    endcase
  end

  // round half up, then saturate to the sample width
  logic signed [P_BITS-1:0]  y_sum;
  logic signed [YW_BITS-1:0] y_wide;
  logic signed [YW_BITS-1:0] y_max;
  logic signed [YW_BITS-1:0] y_min;
  logic [SAMPLE_BITS-1:0]    y_sat;

  always_comb begin
    y_sum  = prod + $signed(P_BITS'(Y_ROUND));
    y_wide = y_sum[P_BITS-1:Y_SHIFT];
    y_max  = $signed({{(YW_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
    y_min  = $signed({{(YW_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}});
    if (y_wide > y_max) begin
      y_sat = y_max[SAMPLE_BITS-1:0];
    end else if (y_wide < y_min) begin
      y_sat = y_min[SAMPLE_BITS-1:0];
    end else begin
      y_sat = y_wide[SAMPLE_BITS-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= DATA_BITS'(y_sat);
      m_tlast <= last_q;
    end
  end

  // checks
  a_last_clears_position: assert property (@(posedge clk) disable iff (rst)
    s_accept && is_last |=> sample_index == '0 && phase_acc == '0)
    else $error("window end did not clear index and phase");

  a_index_advances: assert property (@(posedge clk) disable iff (rst)
    s_accept && !is_last |=> sample_index == $past(idx_eff) + IDX_BITS'(1))
    else $error("sample index did not advance by one");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE)
    else $error("result appeared outside the last step");

  a_stall_holds_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && m_tvalid && !m_tready |=> state == ST_DONE)
    else $error("result dropped while output stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !s_tready ##1 !s_tready)
    else $error("second sample taken during work");

endmodule
`default_nettype wire
